/* design/fdem_pkg.sv */
// Shared types, constants and helper functions of the FAT directory entry matcher.
`default_nettype none

package fdem_pkg;

  // Name storage and limits
  localparam int unsigned MaxNameChars = 48;
  localparam int unsigned NameWords    = 6;
  localparam int unsigned NameBytes    = NameWords * 8;
  localparam int unsigned LenW         = $clog2(MaxNameChars + 1);

  // Long-name segments
  localparam int unsigned LfnChars = 13;
  localparam int unsigned MaxSegs  = (MaxNameChars + LfnChars - 1) / LfnChars;
  localparam int unsigned SegW     = $clog2(MaxSegs + 1);
  localparam int unsigned IdxW     = $clog2(MaxSegs * LfnChars);

  // Directory entry layout
  localparam int unsigned EntryBytes  = 32;
  localparam int unsigned SfnLen      = 11;
  localparam int unsigned CksPreSteps = 6;  // checksum steps done ahead of the input register

  localparam logic [7:0] LfnAttr     = 8'h0F;
  localparam logic [7:0] LfnLastFlag = 8'h40;
  localparam logic [7:0] LfnPad      = 8'hFF;
  localparam logic [7:0] SpaceChar   = 8'h20;
  localparam logic [7:0] DotChar     = 8'h2E;

  // Byte offset of each long-name character within the entry
  localparam logic [4:0] LfnPos [LfnChars] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  // Configuration port
  localparam int unsigned RegCount = 7;
  localparam int unsigned AddrW    = $clog2(RegCount * 8);

  typedef enum logic [2:0] {
    REG_NAME_LENGTH  = 3'd0,
    REG_NAME_CHARS_0 = 3'd1,
    REG_NAME_CHARS_1 = 3'd2,
    REG_NAME_CHARS_2 = 3'd3,
    REG_NAME_CHARS_3 = 3'd4,
    REG_NAME_CHARS_4 = 3'd5,
    REG_NAME_CHARS_5 = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_FOUND    = 2'd1,
    ST_END      = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  typedef logic [EntryBytes-1:0][7:0] entry_t;
  typedef logic [NameBytes-1:0][7:0]  name_t;
  typedef logic [LenW-1:0]            len_t;
  typedef logic [SegW-1:0]            seg_t;

  // Match results handed from the compare logic to the sequence tracker
  typedef struct packed {
    logic       short_hit;
    logic       cur_hit;
    logic       first_hit;
    logic [7:0] cks;
  } match_t;

  // Fold a-z to upper case
  function automatic logic [7:0] upc(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

  // One step of the 8.3 name checksum: rotate right, add the byte
  function automatic logic [7:0] cks_step(logic [7:0] s, logic [7:0] b);
    return {s[0], s[7:1]} + b;
  endfunction

endpackage

`default_nettype wire

/* design/fdem_if.sv */
// Request and result channel interfaces of the FAT directory entry matcher.
`default_nettype none

interface fdem_entry_if;
  logic        valid;
  logic        ready;
  logic        first_of_scan;
  logic [63:0] entry_word_0;
  logic [63:0] entry_word_1;
  logic [63:0] entry_word_2;
  logic [63:0] entry_word_3;

  modport source (
    output valid, first_of_scan, entry_word_0, entry_word_1, entry_word_2, entry_word_3,
    input  ready
  );
  modport sink (
    input  valid, first_of_scan, entry_word_0, entry_word_1, entry_word_2, entry_word_3,
    output ready
  );
endinterface

interface fdem_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] first_cluster;
  logic [31:0] file_size;

  modport source (output valid, status, first_cluster, file_size, input ready);
  modport sink   (input  valid, status, first_cluster, file_size, output ready);
endinterface

`default_nettype wire

/* design/fdem_match.sv */
// Name compare logic: 8.3 short name, long-name segments and short-name checksum.
`default_nettype none

module fdem_match import fdem_pkg::*; (
  input  var entry_t     ent_i,
  input  var name_t      name_i,
  input  var len_t       len_i,
  input  var seg_t       total_i,
  input  var seg_t       seg_i,
  input  var logic [7:0] chk_i,
  input  var logic [7:0] cks_part_i,
  output match_t         match_o
);

  // Name character, zero past the effective length
  function automatic logic [7:0] name_at(name_t n, len_t len, logic [IdxW-1:0] i);
    return (int'(i) < int'(len)) ? n[i] : 8'h00;
  endfunction

  // 8.3 compare: base up to dot or end, space padded, then up to three extension chars
  function automatic logic short_match(entry_t e, name_t n, len_t len);
    logic            ok;
    logic            stop;
    logic [IdxW-1:0] b;
    logic [IdxW-1:0] p;
    logic [7:0]      c;
    ok   = 1'b1;
    stop = 1'b0;
    b    = IdxW'(8);
    for (int k = 0; k < 8; k++) begin
      c = name_at(n, len, IdxW'(k));
      if (!stop && (c == DotChar || c == 8'h00)) begin
        b    = IdxW'(k);
        stop = 1'b1;
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (k < int'(b)) begin
        ok = ok && (upc(e[k]) == upc(name_at(n, len, IdxW'(k))));
      end else begin
        ok = ok && (upc(e[k]) == SpaceChar);
      end
    end
    p = (name_at(n, len, b) == DotChar) ? b + IdxW'(1) : b;
    for (int j = 0; j < 3; j++) begin
      c = name_at(n, len, p + IdxW'(j));
      if (c != 8'h00) begin
        ok = ok && (upc(e[8+j]) == upc(c));
      end else begin
        ok = ok && (upc(e[8+j]) == SpaceChar);
      end
    end
    return ok;
  endfunction

  // One long-name entry against segment seg (1-based)
  function automatic logic lfn_match(entry_t e, name_t n, len_t len, logic [7:0] sig,
                                     seg_t seg, logic [7:0] chk);
    logic            ok;
    logic [IdxW-1:0] off;
    logic [IdxW-1:0] idx;
    logic [7:0]      lo;
    logic [7:0]      hi;
    ok  = (e[0] == sig) && (e[11] == LfnAttr) && (e[26] == 8'h00) && (e[27] == 8'h00) &&
          (e[13] == chk);
    off = IdxW'(LfnChars * (int'(seg) - 1));
    for (int k = 0; k < LfnChars; k++) begin
      idx = off + IdxW'(k);
      lo  = e[LfnPos[k]];
      hi  = e[LfnPos[k] + 1];
      if (int'(idx) < int'(len)) begin
        ok = ok && (upc(lo) == upc(name_at(n, len, idx))) && (hi == 8'h00);
      end else if (int'(idx) == int'(len)) begin
        // terminator right after the last character
        ok = ok && (lo == 8'h00) && (hi == 8'h00);
      end else begin
        ok = ok && (lo == LfnPad) && (hi == LfnPad);
      end
    end
    return ok;
  endfunction

  // Finish the checksum started ahead of the input register
  logic [7:0] cks;
  always_comb begin
    cks = cks_part_i;
    for (int i = CksPreSteps; i < SfnLen; i++) begin
      cks = cks_step(cks, ent_i[i]);
    end
  end

  // Current segment and first-segment (restart) attempts side by side
  always_comb begin
    match_o.short_hit = short_match(ent_i, name_i, len_i);
    match_o.cur_hit   = lfn_match(ent_i, name_i, len_i, 8'(seg_i), seg_i, chk_i);
    match_o.first_hit = lfn_match(ent_i, name_i, len_i, 8'(total_i) | LfnLastFlag,
                                  total_i, ent_i[13]);
    match_o.cks       = cks;
  end

endmodule

`default_nettype wire

/* design/fat_directory_entry_matcher.sv */
// Top level of the FAT directory entry matcher: config registers, pipeline, lookup state.
//
// Requests on entry_i carry one 32-byte directory entry and a first_of_scan flag that
// starts a new lookup. Every request gives exactly one result on result_o: status
// (keep going, found, end of directory, ignored after finish) and, when found, the
// first cluster and file size of the matching entry.
// A request is held in an input register, compared in one pass against the configured
// name (8.3 name, current long-name segment and a restart as first segment, all at
// once) and written to the result register. Throughput is one entry per cycle while the
// receiver takes results, set by that single compare pass between the two registers.
// When the receiver stalls, the result register holds its result and the input register
// still takes one more request; ready drops only when both are full.
// Reset clears the lookup state (as if a sequence had just completed with checksum 0),
// sets name_length to 1 and the name characters to zero. The name is written through
// the APB port at byte address 8*i; the derived name length is registered from the
// written value, so writes are done while no request is in flight.
`default_nettype none

module fat_directory_entry_matcher import fdem_pkg::*; (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  fdem_entry_if.sink            entry_i,
  fdem_result_if.source         result_o,
  input  var logic              psel,
  input  var logic              penable,
  input  var logic              pwrite,
  input  var logic [AddrW-1:0]  paddr,
  input  var logic [63:0]       pwdata,
  output logic     [63:0]       prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------- config
  logic [LenW-1:0]                name_length_q;
  logic [NameWords-1:0][63:0]     name_chars_q;
  logic                           cfg_wr;
  reg_e                           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_length_q <= LenW'(1);
      name_chars_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NAME_LENGTH:  name_length_q   <= pwdata[LenW-1:0];
        REG_NAME_CHARS_0: name_chars_q[0] <= pwdata;
        REG_NAME_CHARS_1: name_chars_q[1] <= pwdata;
        REG_NAME_CHARS_2: name_chars_q[2] <= pwdata;
        REG_NAME_CHARS_3: name_chars_q[3] <= pwdata;
        REG_NAME_CHARS_4: name_chars_q[4] <= pwdata;
        REG_NAME_CHARS_5: name_chars_q[5] <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_NAME_LENGTH:  prdata = 64'(name_length_q);
      REG_NAME_CHARS_0: prdata = name_chars_q[0];
      REG_NAME_CHARS_1: prdata = name_chars_q[1];
      REG_NAME_CHARS_2: prdata = name_chars_q[2];
      REG_NAME_CHARS_3: prdata = name_chars_q[3];
      REG_NAME_CHARS_4: prdata = name_chars_q[4];
      REG_NAME_CHARS_5: prdata = name_chars_q[5];
      default:          prdata = '0;
    endcase
  end

  // Effective length: limited, cut at first zero char; segment count from it
  name_t name;
  len_t  lim;
  len_t  len_d, len_q;
  seg_t  total_d, total_q;

  assign name = name_t'(name_chars_q);

  always_comb begin
    lim = (int'(name_length_q) > MaxNameChars) ? LenW'(MaxNameChars) : name_length_q;
    len_d = lim;
    for (int i = NameBytes - 1; i >= 0; i--) begin
      if (i < int'(lim) && name[i] == 8'h00) len_d = LenW'(i);
    end
    total_d = '0;
    for (int s = 0; s < MaxSegs; s++) begin
      if (int'(len_d) > s * LfnChars) total_d = total_d + seg_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      total_q <= '0;
    end else begin
      len_q   <= len_d;
      total_q <= total_d;
    end
  end

  // ---------------------------------------------------------------- input register
  entry_t     in_ent;
  logic [7:0] cks_part_d;
  logic       s1_valid_q;
  logic       s1_first_q;
  entry_t     s1_ent_q;
  logic [7:0] s1_cks_q;
  logic       s1_advance;
  logic       out_valid_q;

  assign in_ent = {entry_i.entry_word_3, entry_i.entry_word_2,
                   entry_i.entry_word_1, entry_i.entry_word_0};

  // first part of the 8.3 checksum on the incoming entry
  always_comb begin
    cks_part_d = 8'h00;
    for (int i = 0; i < CksPreSteps; i++) begin
      cks_part_d = cks_step(cks_part_d, in_ent[i]);
    end
  end

  assign s1_advance    = s1_valid_q && (!out_valid_q || result_o.ready);
  assign entry_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (entry_i.valid && entry_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_i.valid && entry_i.ready) begin
      s1_first_q <= entry_i.first_of_scan;
      s1_ent_q   <= in_ent;
      s1_cks_q   <= cks_part_d;
    end
  end

  // ---------------------------------------------------------------- compare and state
  seg_t       segs_q, segs_d, seg_b;
  logic [7:0] chk_q, chk_d, chk_b;
  logic       fin_q, fin_d, fin_b;
  match_t     match;
  status_e    status_d;
  logic [31:0] cluster_d, size_d;

  // a new lookup starts from the segment count with cleared checksum and flag
  assign seg_b = s1_first_q ? total_q : segs_q;
  assign chk_b = s1_first_q ? 8'h00   : chk_q;
  assign fin_b = s1_first_q ? 1'b0    : fin_q;

  fdem_match u_match (
    .ent_i      (s1_ent_q),
    .name_i     (name),
    .len_i      (len_q),
    .total_i    (total_q),
    .seg_i      (seg_b),
    .chk_i      (chk_b),
    .cks_part_i (s1_cks_q),
    .match_o    (match)
  );

  always_comb begin
    segs_d    = seg_b;
    chk_d     = chk_b;
    fin_d     = fin_b;
    status_d  = ST_CONTINUE;
    cluster_d = '0;
    size_d    = '0;
    if (fin_b) begin
      status_d = ST_IGNORED;
    end else if (s1_ent_q[0] == 8'h00) begin
      status_d = ST_END;
      fin_d    = 1'b1;
    end else if (match.short_hit ||
                 (total_q != '0 && seg_b == '0 && match.cks == chk_b)) begin
      status_d  = ST_FOUND;
      fin_d     = 1'b1;
      cluster_d = {s1_ent_q[21], s1_ent_q[20], s1_ent_q[27], s1_ent_q[26]};
      size_d    = {s1_ent_q[31], s1_ent_q[30], s1_ent_q[29], s1_ent_q[28]};
    end else if (total_q == '0) begin
      segs_d = '0;
    end else if (seg_b != '0 && seg_b < total_q && match.cur_hit) begin
      segs_d = seg_b - seg_t'(1);
    end else begin
      // restart: this entry tried as first segment
      chk_d  = s1_ent_q[13];
      segs_d = match.first_hit ? (total_q - seg_t'(1)) : total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segs_q <= '0;
      chk_q  <= '0;
      fin_q  <= 1'b0;
    end else if (s1_advance) begin
      segs_q <= segs_d;
      chk_q  <= chk_d;
      fin_q  <= fin_d;
    end
  end

  // ---------------------------------------------------------------- result register
  status_e     status_q;
  logic [31:0] cluster_q;
  logic [31:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      status_q  <= status_d;
      cluster_q <= cluster_d;
      size_q    <= size_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = status_q;
  assign result_o.first_cluster = cluster_q;
  assign result_o.file_size     = size_q;

  // ---------------------------------------------------------------- assertions
  // a found or end result leaves the lookup finished
  a_finish_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && (status_d == ST_FOUND || status_d == ST_END) |=> fin_q)
    else $error("lookup not finished after found/end");

  // once finished, a request without a new scan is ignored
  a_ignore_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && fin_q && !s1_first_q |=> status_q == ST_IGNORED)
    else $error("request after finish not ignored");

  // only a found result carries cluster and size
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_FOUND |-> cluster_q == '0 && size_q == '0)
    else $error("non-found result with nonzero fields");

  // a request leaving the input register always lands in the result register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_q)
    else $error("result lost between stages");

endmodule

`default_nettype wire

/* tb/fat_directory_entry_matcher_test.sv */
// Self-checking testbench for the FAT directory entry matcher: directed and random scans.
module fat_directory_entry_matcher_test;
  import fdem_pkg::*;

  localparam int unsigned PhaseCount    = 14;
  localparam int unsigned ItemsPerPhase = 38;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct packed {
    status_e     status;
    logic [31:0] cluster;
    logic [31:0] size;
  } outcome_t;

  typedef struct packed {
    logic   start;
    entry_t ent;
  } dir_item_t;

  logic clk_i;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [63:0]      pwdata;
  logic [63:0]      prdata;
  logic             pready;

  fdem_entry_if  ent_if ();
  fdem_result_if res_if ();

  fat_directory_entry_matcher dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (ent_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the name registers and of the lookup state
  logic [5:0]  name_len_reg = 6'd1;
  logic [63:0] name_words [NameWords] = '{default: '0};
  logic [7:0]  segs_left = '0;
  logic [7:0]  held_cks  = '0;
  logic        scan_done = 1'b0;

  // Scratch name bytes for the next configuration
  logic [7:0] cfg_bytes [NameBytes];

  dir_item_t   entry_backlog [$];
  outcome_t    pending_outcomes [$];
  dir_item_t   next_entry;
  outcome_t    want;
  int unsigned entry_gap   = 0;
  int unsigned result_hold = 0;
  int unsigned queued      = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  // Length of the sought name: register clamped, cut at the first zero char
  function automatic int unsigned name_len_eff();
    int unsigned lim;
    lim = name_len_reg;
    if (lim > MaxNameChars) lim = MaxNameChars;
    for (int unsigned i = 0; i < lim; i++) begin
      if (name_words[i / 8][(i % 8) * 8 +: 8] == 8'h00) return i;
    end
    return lim;
  endfunction

  function automatic logic [7:0] name_byte(int unsigned i, int unsigned len);
    if (i >= len || i >= MaxNameChars) return 8'h00;
    return name_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // 8.3 compare: base until dot, space pad, implicit dot, extension, space pad
  function automatic bit short_hit(entry_t e, int unsigned len);
    int unsigned p, k;
    logic [7:0]  c;
    p = 0;
    k = 0;
    while (k < 8) begin
      c = name_byte(p, len);
      if (c == DotChar || c == 8'h00) break;
      if (fold(e[k]) != fold(c)) return 1'b0;
      k++;
      p++;
    end
    while (k < 8) begin
      if (fold(e[k]) != SpaceChar) return 1'b0;
      k++;
    end
    if (name_byte(p, len) == DotChar) p++;
    while (k < SfnLen) begin
      c = name_byte(p, len);
      if (c == 8'h00) break;
      if (fold(e[k]) != fold(c)) return 1'b0;
      p++;
      k++;
    end
    while (k < SfnLen) begin
      if (fold(e[k]) != SpaceChar) return 1'b0;
      k++;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] sfn_sum(entry_t e);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < SfnLen; i++) s = {s[0], s[7:1]} + e[i];
    return s;
  endfunction

  // One long-name segment: header bytes, 13 UCS-2 chars, terminator, 0xFFFF pad
  function automatic bit lfn_hit(entry_t e, logic [7:0] sig, int unsigned seg,
                                 logic [7:0] chk, int unsigned len);
    int unsigned off, k;
    logic [7:0]  c;
    off = LfnChars * (seg - 1);
    k = 0;
    if (e[0] != sig) return 1'b0;
    if (e[11] != LfnAttr || e[26] != 8'h00 || e[27] != 8'h00) return 1'b0;
    if (e[13] != chk) return 1'b0;
    while (k < LfnChars) begin
      c = name_byte(off + k, len);
      if (c == 8'h00) break;
      if (fold(e[LfnPos[k]]) != fold(c) || e[LfnPos[k] + 1] != 8'h00) return 1'b0;
      k++;
    end
    if (k < LfnChars) begin
      if (e[LfnPos[k]] != 8'h00 || e[LfnPos[k] + 1] != 8'h00) return 1'b0;
      k++;
      while (k < LfnChars) begin
        if (e[LfnPos[k]] != LfnPad || e[LfnPos[k] + 1] != LfnPad) return 1'b0;
        k++;
      end
    end
    return 1'b1;
  endfunction

  // Expected result of one entry; advances the shadow lookup state
  function automatic outcome_t lookup_entry(logic start, entry_t e);
    outcome_t    r;
    int unsigned len, segs;
    logic [7:0]  seg;
    len = name_len_eff();
    segs = (len + LfnChars - 1) / LfnChars;
    r.status = ST_CONTINUE;
    r.cluster = '0;
    r.size = '0;
    if (start) begin
      segs_left = 8'(segs);
      held_cks = '0;
      scan_done = 1'b0;
    end
    if (scan_done) begin
      r.status = ST_IGNORED;
      return r;
    end
    if (e[0] == 8'h00) begin
      scan_done = 1'b1;
      r.status = ST_END;
      return r;
    end
    seg = segs_left;
    if (short_hit(e, len) || (segs != 0 && seg == 0 && sfn_sum(e) == held_cks)) begin
      r.status = ST_FOUND;
      r.cluster = {e[21], e[20], e[27], e[26]};
      r.size = {e[31], e[30], e[29], e[28]};
      scan_done = 1'b1;
      return r;
    end
    if (segs == 0) begin
      segs_left = '0;
      return r;
    end
    if (seg != 0 && seg < segs && lfn_hit(e, seg, seg, held_cks, len)) begin
      segs_left = seg - 8'd1;
      return r;
    end
    // try this entry as the first segment of a new sequence
    held_cks = e[13];
    if (lfn_hit(e, 8'(segs) | LfnLastFlag, segs, held_cks, len)) segs_left = 8'(segs - 1);
    else segs_left = 8'(segs);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Entry builders
  // ---------------------------------------------------------------------------

  function automatic entry_t rand_entry();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (fold(c) >= 8'h41 && fold(c) <= 8'h5A) begin
      return $urandom_range(0, 1) ? fold(c) : (fold(c) | 8'h20);
    end
    return c;
  endfunction

  // Unrelated entries: deleted, long-name lookalikes, plain garbage
  function automatic entry_t noise_entry();
    entry_t      e;
    int unsigned r;
    e = rand_entry();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      e[0] = 8'hE5;
    end else if (r < 30) begin
      e[11] = LfnAttr;
      e[26] = 8'h00;
      e[27] = 8'h00;
    end
    if (e[0] == 8'h00) e[0] = 8'h01;
    return e;
  endfunction

  function automatic entry_t end_entry();
    entry_t e;
    e = rand_entry();
    e[0] = 8'h00;
    return e;
  endfunction

  function automatic entry_t corrupt(entry_t e);
    int unsigned i;
    i = $urandom_range(0, EntryBytes - 1);
    e[i] = e[i] ^ (8'h01 << $urandom_range(0, 7));
    return e;
  endfunction

  // Short entry that spells the configured name in 8.3 form, random case
  function automatic entry_t make_short(int unsigned len);
    entry_t      e;
    int unsigned p, k;
    logic [7:0]  c;
    e = rand_entry();
    p = 0;
    k = 0;
    while (k < 8) begin
      c = name_byte(p, len);
      if (c == DotChar || c == 8'h00) break;
      e[k] = mixed_case(c);
      k++;
      p++;
    end
    while (k < 8) begin
      e[k] = SpaceChar;
      k++;
    end
    if (name_byte(p, len) == DotChar) p++;
    while (k < SfnLen) begin
      c = name_byte(p, len);
      if (c == 8'h00) break;
      e[k] = mixed_case(c);
      p++;
      k++;
    end
    while (k < SfnLen) begin
      e[k] = SpaceChar;
      k++;
    end
    return e;
  endfunction

  // Short entry with a random name whose checksum comes out as chk
  function automatic entry_t make_closing(logic [7:0] chk);
    entry_t     e;
    logic [7:0] s;
    e = rand_entry();
    e[0] = 8'($urandom_range(8'h21, 8'h7E));
    s = '0;
    for (int i = 0; i < SfnLen - 1; i++) s = {s[0], s[7:1]} + e[i];
    e[SfnLen - 1] = chk - {s[0], s[7:1]};
    return e;
  endfunction

  function automatic entry_t make_lfn(int unsigned seg, logic [7:0] sig, logic [7:0] chk,
                                      int unsigned len);
    entry_t      e;
    int unsigned off, k;
    logic [7:0]  c;
    e = rand_entry();
    e[0] = sig;
    e[11] = LfnAttr;
    e[13] = chk;
    e[26] = 8'h00;
    e[27] = 8'h00;
    off = LfnChars * (seg - 1);
    k = 0;
    while (k < LfnChars) begin
      c = name_byte(off + k, len);
      if (c == 8'h00) break;
      e[LfnPos[k]] = mixed_case(c);
      e[LfnPos[k] + 1] = 8'h00;
      k++;
    end
    if (k < LfnChars) begin
      e[LfnPos[k]] = 8'h00;
      e[LfnPos[k] + 1] = 8'h00;
      k++;
      while (k < LfnChars) begin
        e[LfnPos[k]] = LfnPad;
        e[LfnPos[k] + 1] = LfnPad;
        k++;
      end
    end
    return e;
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 65) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 75) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 83) return DotChar;
    if (r < 87) return SpaceChar;
    if (r < 95) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(1, 255));
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  task automatic push_entry(logic start, entry_t e);
    dir_item_t it;
    it.start = start;
    it.ent = e;
    entry_backlog.push_back(it);
    queued++;
  endtask

  // APB write: setup cycle, access cycle, register written at the access edge
  task automatic apb_write(reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NAME_LENGTH) name_len_reg = val[5:0];
    else name_words[int'(idx) - int'(REG_NAME_CHARS_0)] = val;
  endtask

  task automatic write_name(logic [5:0] len_val);
    logic [63:0] word;
    for (int w = 0; w < NameWords; w++) begin
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = cfg_bytes[w * 8 + b];
      apb_write(reg_e'(int'(REG_NAME_CHARS_0) + w), word);
    end
    apb_write(REG_NAME_LENGTH, 64'(len_val));
  endtask

  // checked between edges so the driver's and monitor's updates have settled
  task automatic wait_idle();
    while (entry_backlog.size() != 0 || ent_if.valid || pending_outcomes.size() != 0) begin
      @(negedge clk_i);
    end
    // two-stage pipeline, plus margin
    repeat (4) @(posedge clk_i);
  endtask

  // One lookup: leading clutter, then a long-name sequence, a short name,
  // an end of directory or just clutter, then trailing clutter
  task automatic add_scan(logic start);
    int unsigned len, segs, kind;
    entry_t      e, close_e;
    logic [7:0]  chk;
    logic        lead;
    len = name_len_eff();
    segs = (len + LfnChars - 1) / LfnChars;
    lead = start;
    repeat ($urandom_range(0, 2)) begin
      push_entry(lead, noise_entry());
      lead = 1'b0;
    end
    kind = $urandom_range(0, 99);
    if (segs != 0 && kind < 60) begin
      close_e = make_closing(8'($urandom_range(0, 255)));
      chk = sfn_sum(close_e);
      for (int s = segs; s >= 1; s--) begin
        if ($urandom_range(0, 99) < 5) begin
          push_entry(lead, noise_entry());
          lead = 1'b0;
        end
        e = make_lfn(s, (s == segs) ? (8'(s) | LfnLastFlag) : 8'(s), chk, len);
        if ($urandom_range(0, 99) < 6) e = corrupt(e);
        push_entry(lead, e);
        lead = 1'b0;
      end
      if ($urandom_range(0, 99) < 10) close_e = corrupt(close_e);
      push_entry(lead, close_e);
    end else if (kind < 80) begin
      e = make_short(len);
      if ($urandom_range(0, 99) < 10) e = corrupt(e);
      push_entry(lead, e);
    end else if (kind < 90) begin
      push_entry(lead, end_entry());
    end else begin
      push_entry(lead, noise_entry());
    end
    repeat ($urandom_range(0, 2)) push_entry(1'b0, noise_entry());
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatches < 100) begin
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got,
               exp_val);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: predicts each accepted entry, then loads the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ent_if.valid && ent_if.ready) begin
        pending_outcomes.push_back(lookup_entry(ent_if.first_of_scan,
            {ent_if.entry_word_3, ent_if.entry_word_2, ent_if.entry_word_1,
             ent_if.entry_word_0}));
      end
      if (!ent_if.valid || ent_if.ready) begin
        if (entry_gap != 0 || entry_backlog.size() == 0) begin
          if (entry_gap != 0) entry_gap--;
          ent_if.valid <= 1'b0;
        end else begin
          next_entry = entry_backlog.pop_front();
          ent_if.valid <= 1'b1;
          ent_if.first_of_scan <= next_entry.start;
          ent_if.entry_word_0 <= next_entry.ent[7:0];
          ent_if.entry_word_1 <= next_entry.ent[15:8];
          ent_if.entry_word_2 <= next_entry.ent[23:16];
          ent_if.entry_word_3 <= next_entry.ent[31:24];
          entry_gap = gap_cycles();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor with random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with none pending", 32'(res_if.status), '0);
        end else begin
          want = pending_outcomes.pop_front();
          if (res_if.status !== want.status) begin
            report_mismatch("status", 32'(res_if.status), 32'(want.status));
          end
          if (res_if.first_cluster !== want.cluster) begin
            report_mismatch("first_cluster", res_if.first_cluster, want.cluster);
          end
          if (res_if.file_size !== want.size) begin
            report_mismatch("file_size", res_if.file_size, want.size);
          end
        end
      end
      if (result_hold != 0) begin
        result_hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        result_hold = gap_cycles();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, then per phase a name setting and a batch of scans
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned len, phase_base, r;
    entry_t      c, e;
    logic [7:0]  chk;
    bit          first_scan;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ent_if.valid = 1'b0;
    ent_if.first_of_scan = 1'b0;
    ent_if.entry_word_0 = '0;
    ent_if.entry_word_1 = '0;
    ent_if.entry_word_2 = '0;
    ent_if.entry_word_3 = '0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) wait_idle();
      calm = ($urandom_range(0, 3) == 0);

      // name setting for this phase
      for (int i = 0; i < NameBytes; i++) cfg_bytes[i] = name_char();
      case (ph)
        0: begin
          for (int i = 0; i < NameBytes; i++) cfg_bytes[i] = 8'h00;
          for (int i = 0; i < 10; i++) cfg_bytes[i] = 8'("Kernel.sys" >> (8 * (9 - i)));
          write_name(6'd10);
        end
        1: write_name(6'd48);
        2: write_name(6'd13);
        3: begin
          for (int i = 0; i < NameBytes; i++) cfg_bytes[i] = 8'hFF;
          write_name(6'd63);
        end
        4: write_name(6'd1);
        5: write_name(6'd0);
        6: begin
          // same as after reset: empty name
          for (int i = 0; i < NameBytes; i++) cfg_bytes[i] = 8'h00;
          write_name(6'd1);
        end
        7: begin
          cfg_bytes[6] = 8'h00;
          write_name(6'd20);
        end
        8: write_name(6'd26);
        default: begin
          r = $urandom_range(0, 99);
          if (r < 10) cfg_bytes[$urandom_range(0, NameBytes - 1)] = 8'h00;
          write_name(6'($urandom_range(0, 99) < 70 ? $urandom_range(1, 20)
                                                   : $urandom_range(0, 63)));
        end
      endcase
      len = name_len_eff();
      phase_base = queued;

      if (ph == 0) begin
        // no lookup started since reset: checksum zero closes a sequence
        push_entry(1'b0, make_closing(8'h00));
        push_entry(1'b0, noise_entry());
        push_entry(1'b1, '1);
        c = make_closing(8'($urandom_range(0, 255)));
        chk = sfn_sum(c);
        push_entry(1'b0, make_lfn(1, 8'h01 | LfnLastFlag, chk, len));
        push_entry(1'b0, c);
        push_entry(1'b0, noise_entry());
        push_entry(1'b1, make_short(len));
        // sequence broken in the middle
        push_entry(1'b1, make_lfn(1, 8'h01 | LfnLastFlag, chk, len));
        push_entry(1'b0, noise_entry());
        push_entry(1'b0, c);
        // closing entry with a bad checksum, then a fresh sequence
        push_entry(1'b1, make_lfn(1, 8'h01 | LfnLastFlag, chk, len));
        e = c;
        e[1] = e[1] ^ 8'h01;
        push_entry(1'b0, e);
        push_entry(1'b0, make_lfn(1, 8'h01 | LfnLastFlag, chk, len));
        push_entry(1'b0, c);
        push_entry(1'b1, '0);
      end else if (ph == 1) begin
        // full four-segment sequence at the longest name
        c = make_closing(8'($urandom_range(0, 255)));
        chk = sfn_sum(c);
        push_entry(1'b1, make_lfn(4, 8'h04 | LfnLastFlag, chk, len));
        for (int s = 3; s >= 1; s--) push_entry(1'b0, make_lfn(s, 8'(s), chk, len));
        push_entry(1'b0, c);
      end

      first_scan = 1'b1;
      while (queued - phase_base < ItemsPerPhase) begin
        if (first_scan) add_scan(ph != 2 && $urandom_range(0, 1) != 0);
        else add_scan($urandom_range(0, 4) != 0);
        first_scan = 1'b0;
      end

      // leave a sequence open so the next, shorter name sees a counter above its count
      if (ph == 1) push_entry(1'b1, make_lfn(4, 8'h04 | LfnLastFlag, chk, len));
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/fdem_pkg.sv
design/fdem_if.sv
design/fdem_match.sv
design/fat_directory_entry_matcher.sv
tb/fat_directory_entry_matcher_test.sv
